@@ hdl/tncp_pkg.sv @@
package tncp_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam logic [12:0] HALF_W = 13'(SCREEN_WIDTH / 2);
  localparam logic [12:0] HALF_H = 13'(SCREEN_HEIGHT / 2);

  // register indexes of the configuration port
  localparam logic [2:0] REG_ORIGIN  = 3'd0;
  localparam logic [2:0] REG_RIGHT   = 3'd1;
  localparam logic [2:0] REG_FORWARD = 3'd2;
  localparam logic [2:0] REG_UP      = 3'd3;
  localparam logic [2:0] REG_NEAR    = 3'd4;
  localparam logic [2:0] REG_HSCALE  = 3'd5;
  localparam logic [2:0] REG_VSCALE  = 3'd6;

  // clipping cases
  localparam logic [1:0] MODE_ALL = 2'd0;
  localparam logic [1:0] MODE_ONE = 2'd1;  // one corner behind, two triangles
  localparam logic [1:0] MODE_TWO = 2'd2;  // two corners behind, one triangle

  // vertex selectors for emission
  localparam logic [2:0] VS_A  = 3'd0;
  localparam logic [2:0] VS_B  = 3'd1;
  localparam logic [2:0] VS_C  = 3'd2;
  localparam logic [2:0] VS_BN = 3'd3;
  localparam logic [2:0] VS_CN = 3'd4;

  localparam int DIV_NW = 54;
  localparam int DIV_DW = 34;

  typedef struct packed {
    logic signed [24:0] lat_r;
    logic signed [24:0] lat_u;
    logic signed [24:0] depth;
    logic [15:0]        u;
    logic [15:0]        v;
  } vert_t;

  function automatic logic [2:0] emit_sel(input logic [1:0] mode, input logic [2:0] e);
    logic [2:0] s;
    s = VS_A;
    if (mode == MODE_ONE) begin
      unique case (e)
        3'd0, 3'd3: s = VS_BN;
        3'd1, 3'd5: s = VS_C;
        3'd2:       s = VS_CN;
        default:    s = VS_B;
      endcase
    end else if (mode == MODE_TWO) begin
      unique case (e)
        3'd0:    s = VS_A;
        3'd1:    s = VS_BN;
        default: s = VS_CN;
      endcase
    end else begin
      unique case (e)
        3'd0:    s = VS_A;
        3'd1:    s = VS_B;
        default: s = VS_C;
      endcase
    end
    return s;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [DIV_NW-1:0] x);
    logic signed [15:0] r;
    if (x < -54'sd32768) r = -16'sd32768;
    else if (x > 54'sd32767) r = 16'sd32767;
    else r = x[15:0];
    return r;
  endfunction

endpackage

@@ hdl/triangle_near_clip_project.sv @@
// Triangle near-plane clipper and perspective projector. Corners arrive one
// transaction each; the first two are stored and the third starts the work:
// 27 multiply-accumulate steps move the corners into the camera frame, then
// each clip point needs four divisions and each emitted vertex up to two, all
// through one bit-serial divider and one shared 27x27 multiplier. Input is
// not taken until the last result has been loaded into the output register
// or the triangle is discarded; that register holds a result until it is taken.
module triangle_near_clip_project (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v, zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // screen_x, screen_y, vertex_depth, out_u, out_v, zero fill
  output logic        m_tuser,   // triangle_end
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data
);
  import tncp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DOT  = 3'd1;
  localparam logic [2:0] S_FLAG = 3'd2;
  localparam logic [2:0] S_ROT  = 3'd3;
  localparam logic [2:0] S_CLIP = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [59:0] camera_origin;
  logic [47:0] axis_right, axis_forward, axis_up;
  logic [18:0] near_distance;
  logic [19:0] horizontal_scale, vertical_scale;

  logic [59:0] pos_mem [3];
  logic [31:0] tex_mem [3];
  logic [1:0]  cnt;

  logic [2:0]  state;
  logic [1:0]  j, m, k, q, mode, rot;
  logic [2:0]  ph, e;
  logic        cp;
  logic signed [39:0] acc;
  logic signed [53:0] prod, t1;
  logic signed [15:0] sx, sy;
  vert_t v_a, v_b, v_c, v_bn, v_cn;

  logic signed [26:0] mul_a, mul_b;
  logic               div_start, div_done;
  logic signed [DIV_NW-1:0] div_n, div_q;
  logic signed [DIV_DW-1:0] div_d;

  logic [59:0]        pos_cur;
  logic signed [20:0] d_k;
  logic signed [15:0] ax_k;
  logic [47:0]        ax_sel;
  logic signed [39:0] acc_next;
  logic signed [24:0] dot_res;
  logic               f0, f1, f2;
  vert_t              v_o, v_p;
  logic signed [25:0] clip_num, clip_den, clip_diff;
  logic signed [DIV_NW-1:0] clip_base, clip_res;
  logic               tend, lst;
  logic [19:0]        dep20;
  logic               load_out;

  assign s_tready = (state == S_IDLE);
  assign load_out = (state == S_EMIT) && (ph == 3'd7) && (!m_tvalid || m_tready);

  always_comb begin
    pos_cur = pos_mem[j];
    unique case (m)
      2'd0:    ax_sel = axis_right;
      2'd1:    ax_sel = axis_forward;
      default: ax_sel = axis_up;
    endcase
    unique case (k)
      2'd0: begin
        d_k  = 21'(signed'(pos_cur[19:0])) - 21'(signed'(camera_origin[19:0]));
        ax_k = ax_sel[15:0];
      end
      2'd1: begin
        d_k  = 21'(signed'(pos_cur[39:20])) - 21'(signed'(camera_origin[39:20]));
        ax_k = ax_sel[31:16];
      end
      default: begin
        d_k  = 21'(signed'(pos_cur[59:40])) - 21'(signed'(camera_origin[59:40]));
        ax_k = ax_sel[47:32];
      end
    endcase
    acc_next = ((k == 2'd0) ? 40'sd0 : acc) + 40'(prod);
    dot_res  = 25'(acc_next >>> 14);

    f0 = 26'(v_a.depth) > $signed({7'b0, near_distance});
    f1 = 26'(v_b.depth) > $signed({7'b0, near_distance});
    f2 = 26'(v_c.depth) > $signed({7'b0, near_distance});

    v_o       = cp ? v_c : v_b;
    clip_num  = $signed({7'b0, near_distance}) - 26'(v_a.depth);
    clip_den  = 26'(v_o.depth) - 26'(v_a.depth);
    unique case (q)
      2'd0: begin
        clip_diff = 26'(v_o.lat_r) - 26'(v_a.lat_r);
        clip_base = DIV_NW'(v_a.lat_r);
      end
      2'd1: begin
        clip_diff = 26'(v_o.lat_u) - 26'(v_a.lat_u);
        clip_base = DIV_NW'(v_a.lat_u);
      end
      2'd2: begin
        clip_diff = $signed({10'b0, v_o.u}) - $signed({10'b0, v_a.u});
        clip_base = $signed({38'b0, v_a.u});
      end
      default: begin
        clip_diff = $signed({10'b0, v_o.v}) - $signed({10'b0, v_a.v});
        clip_base = $signed({38'b0, v_a.v});
      end
    endcase
    clip_res = clip_base + div_q;

    unique case (emit_sel(mode, e))
      VS_A:    v_p = v_a;
      VS_B:    v_p = v_b;
      VS_C:    v_p = v_c;
      VS_BN:   v_p = v_bn;
      default: v_p = v_cn;
    endcase
    tend = (e == 3'd2) || (e == 3'd5);
    lst  = (mode == MODE_ONE) ? (e == 3'd5) : (e == 3'd2);
    if (v_p.depth < 0) dep20 = '0;
    else if (v_p.depth > 25'sd1048575) dep20 = 20'hFFFFF;
    else dep20 = v_p.depth[19:0];

    // shared multiplier operands
    mul_a = 27'(ax_k);
    mul_b = 27'(d_k);
    div_start = 1'b0;
    div_n = prod;
    div_d = DIV_DW'(clip_den);
    if (state == S_CLIP) begin
      mul_a = 27'(clip_diff);
      mul_b = 27'(clip_num);
      div_start = (ph == 3'd1);
    end else if (state == S_EMIT) begin
      div_d = DIV_DW'(v_p.depth) <<< 8;
      unique case (ph)
        3'd0: begin
          mul_a = $signed({7'b0, horizontal_scale});
          mul_b = 27'(v_p.lat_r);
        end
        3'd1, 3'd4: begin
          mul_a = (ph == 3'd1) ? $signed({14'b0, HALF_W}) : $signed({14'b0, HALF_H});
          mul_b = 27'(v_p.depth);
        end
        3'd2: begin
          div_start = 1'b1;
          div_n = t1 + (prod <<< 8);
        end
        3'd3: begin
          mul_a = $signed({7'b0, vertical_scale});
          mul_b = 27'(v_p.lat_u);
        end
        3'd5: begin
          div_start = 1'b1;
          div_n = (prod <<< 8) - t1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) prod <= mul_a * mul_b;

  tncp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_origin    <= '0;
      axis_right       <= 48'd16384;
      axis_forward     <= 48'd1073741824;
      axis_up          <= 48'd70368744177664;
      near_distance    <= 19'd1024;
      horizontal_scale <= 20'd81920;
      vertical_scale   <= 20'd61440;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN:  camera_origin    <= cfg_data;
        REG_RIGHT:   axis_right       <= cfg_data[47:0];
        REG_FORWARD: axis_forward     <= cfg_data[47:0];
        REG_UP:      axis_up          <= cfg_data[47:0];
        REG_NEAR:    near_distance    <= cfg_data[18:0];
        REG_HSCALE:  horizontal_scale <= cfg_data[19:0];
        REG_VSCALE:  vertical_scale   <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pos_mem[cnt] <= s_tdata[59:0];
      tex_mem[cnt] <= s_tdata[91:60];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
      ph       <= '0;
    end else begin
      if (m_tvalid && m_tready && !load_out) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (cnt == 2'd2) begin
              cnt   <= '0;
              state <= S_DOT;
              j <= '0; m <= '0; k <= '0; ph <= '0;
            end else begin
              cnt <= cnt + 2'd1;
            end
          end
        end
        S_DOT: begin
          ph <= {2'b0, ~ph[0]};
          if (ph[0]) begin
            acc <= acc_next;
            if (k == 2'd2) begin
              k <= '0;
              unique case (j)
                2'd0: begin
                  if (m == 2'd0) v_a.lat_r <= dot_res;
                  else if (m == 2'd1) v_a.depth <= dot_res;
                  else v_a.lat_u <= dot_res;
                  {v_a.v, v_a.u} <= tex_mem[j];
                end
                2'd1: begin
                  if (m == 2'd0) v_b.lat_r <= dot_res;
                  else if (m == 2'd1) v_b.depth <= dot_res;
                  else v_b.lat_u <= dot_res;
                  {v_b.v, v_b.u} <= tex_mem[j];
                end
                default: begin
                  if (m == 2'd0) v_c.lat_r <= dot_res;
                  else if (m == 2'd1) v_c.depth <= dot_res;
                  else v_c.lat_u <= dot_res;
                  {v_c.v, v_c.u} <= tex_mem[j];
                end
              endcase
              if (m == 2'd2) begin
                m <= '0;
                if (j == 2'd2) state <= S_FLAG;
                else j <= j + 2'd1;
              end else begin
                m <= m + 2'd1;
              end
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        S_FLAG: begin
          ph <= '0; e <= '0; cp <= 1'b0; q <= '0;
          priority if (f0 && f1 && f2) begin
            mode <= MODE_ALL; rot <= 2'd0; state <= S_EMIT;
          end else if (f1 && f2) begin
            mode <= MODE_ONE; rot <= 2'd0; state <= S_ROT;
          end else if (f2 && f0) begin
            mode <= MODE_ONE; rot <= 2'd1; state <= S_ROT;
          end else if (f0 && f1) begin
            mode <= MODE_ONE; rot <= 2'd2; state <= S_ROT;
          end else if (f0) begin
            mode <= MODE_TWO; rot <= 2'd0; state <= S_ROT;
          end else if (f1) begin
            mode <= MODE_TWO; rot <= 2'd1; state <= S_ROT;
          end else if (f2) begin
            mode <= MODE_TWO; rot <= 2'd2; state <= S_ROT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ROT: begin
          // odd corner to the front
          if (rot == 2'd0) begin
            state <= S_CLIP;
          end else begin
            v_a <= v_b; v_b <= v_c; v_c <= v_a;
            rot <= rot - 2'd1;
          end
        end
        S_CLIP: begin
          unique case (ph)
            3'd0: begin
              if (clip_den == 26'sd0) begin
                if (cp) v_cn <= v_a;
                else v_bn <= v_a;
                q <= '0;
                cp <= 1'b1;
                if (cp) state <= S_EMIT;
              end else begin
                ph <= 3'd1;
              end
            end
            3'd1: ph <= 3'd2;
            default: begin
              if (div_done) begin
                ph <= '0;
                if (cp) begin
                  v_cn.depth <= $signed({6'b0, near_distance});
                  unique case (q)
                    2'd0:    v_cn.lat_r <= clip_res[24:0];
                    2'd1:    v_cn.lat_u <= clip_res[24:0];
                    2'd2:    v_cn.u     <= clip_res[15:0];
                    default: v_cn.v     <= clip_res[15:0];
                  endcase
                end else begin
                  v_bn.depth <= $signed({6'b0, near_distance});
                  unique case (q)
                    2'd0:    v_bn.lat_r <= clip_res[24:0];
                    2'd1:    v_bn.lat_u <= clip_res[24:0];
                    2'd2:    v_bn.u     <= clip_res[15:0];
                    default: v_bn.v     <= clip_res[15:0];
                  endcase
                end
                q <= q + 2'd1;
                if (q == 2'd3) begin
                  cp <= 1'b1;
                  if (cp) state <= S_EMIT;
                end
              end
            end
          endcase
        end
        S_EMIT: begin
          unique case (ph)
            3'd0: begin
              if (v_p.depth > 0) begin
                ph <= 3'd1;
              end else begin
                // no projection term, point lands mid screen
                sx <= 16'(HALF_W);
                sy <= 16'(HALF_H);
                ph <= 3'd7;
              end
            end
            3'd1, 3'd4: begin
              t1 <= prod;
              ph <= ph + 3'd1;
            end
            3'd2, 3'd5: ph <= ph + 3'd1;
            3'd3: begin
              if (div_done) begin
                sx <= sat16(div_q);
                ph <= 3'd4;
              end
            end
            3'd6: begin
              if (div_done) begin
                sy <= sat16(div_q);
                ph <= 3'd7;
              end
            end
            default: begin
              if (load_out) begin
                m_tvalid <= 1'b1;
                m_tdata  <= {4'b0, v_p.v, v_p.u, dep20, sy, sx};
                m_tuser  <= tend;
                m_tlast  <= lst;
                ph       <= '0;
                e        <= e + 3'd1;
                if (lst) state <= S_IDLE;
              end
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("corner count out of range");

  a_third_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && cnt == 2'd2 |=> state == S_DOT)
    else $error("third corner did not start transform");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("last result not on a triangle end");

endmodule

@@ hdl/tncp_div.sv @@
module tncp_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [tncp_pkg::DIV_NW-1:0] dividend,
  input  logic signed [tncp_pkg::DIV_DW-1:0] divisor,
  output logic                              done,
  output logic signed [tncp_pkg::DIV_NW-1:0] quotient
);
  import tncp_pkg::*;

  logic                busy;
  logic [5:0]          cnt;
  logic [DIV_DW-1:0]   rem;
  logic [DIV_NW-1:0]   quo;
  logic [DIV_DW-1:0]   dvs;
  logic                neg;
  logic [DIV_DW:0]     rem_sh;
  logic                ge;
  logic [DIV_DW-1:0]   rem_next;

  // one quotient bit per cycle, restoring, on magnitudes
  always_comb begin
    rem_sh   = {rem, quo[DIV_NW-1]};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? DIV_DW'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_DW-1:0];
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend[DIV_NW-1] ? DIV_NW'(-dividend) : DIV_NW'(dividend);
        dvs  <= divisor[DIV_DW-1] ? DIV_DW'(-divisor) : DIV_DW'(divisor);
        neg  <= dividend[DIV_NW-1] ^ divisor[DIV_DW-1];
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DIV_NW-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
